// ----- rtl/rc4iv_pkg.sv -----
`timescale 1ns / 1ps

package rc4iv_pkg;

   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 256;
   localparam int KEY_W      = 64;
   localparam int LEN_W      = 5;
   localparam int MAX_SECRET = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH   = 2'd2;

   // Commands from the controller; at most one phase active per cycle
   typedef struct packed {
      logic start;      // start item transfer: latch IV, clear counters
      logic cipher;     // cipher item transfer: latch byte, advance i
      logic init;       // write identity entry
      logic ks_read;    // key schedule: take S[n], read S[j]
      logic ks_wr_n;    // key schedule: S[n] <= S[j]
      logic ks_wr_j;    // key schedule: S[j] <= old S[n], read S[n+1]
      logic gen_read;   // generator: take S[i], read S[j]
      logic gen_wr_i;   // generator: S[i] <= S[j]
      logic gen_wr_j;   // generator: S[j] <= old S[i], read S[si+sj]
      logic gen_out;    // generator: load result register
   } cmd_type;

   typedef struct packed {
      logic n_last;     // sweep counter at final entry
      logic out_free;   // result register can take a new byte
   } status_type;

endpackage

// ----- rtl/rc4iv_ram.sv -----
`timescale 1ns / 1ps

module rc4iv_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write-first: a read of the address being written returns the new data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rc4iv_dp.sv -----
`timescale 1ns / 1ps

module rc4iv_dp
   import rc4iv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_result_byte,
   input  cmd_type              cmd,
   output status_type           status
);

   localparam int ADDR_W = $clog2(PERM_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(PERM_DEPTH - 1);

   logic [KEY_W-1:0]  key_low_ff, key_high_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [ADDR_W-1:0] n_ff, n_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] si_ff, si_in;
   logic [BYTE_W-1:0] sj_ff, sj_in;
   logic [BYTE_W-1:0] iv_ff, iv_in;
   logic [BYTE_W-1:0] text_ff, text_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;

   logic [LEN_W-1:0]     used_len;
   logic [2*KEY_W-1:0]   secret_all;
   logic [3:0]           secret_idx;
   logic [LEN_W-1:0]     pos_dec;
   logic [BYTE_W-1:0]    key_byte;
   logic [ADDR_W-1:0]    ks_sum, gen_sum, out_addr;
   logic                 out_free;

   rc4iv_ram #(
      .DATA_W(BYTE_W),
      .DEPTH (PERM_DEPTH)
   ) u_perm (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      if (len_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_SECRET)) begin
         used_len = LEN_W'(MAX_SECRET);
      end else begin
         used_len = len_ff;
      end
   end

   // Position zero of the cyclic key is the IV, the rest are secret bytes
   assign secret_all = {key_high_ff, key_low_ff};
   assign pos_dec    = pos_ff - LEN_W'(1);
   assign secret_idx = pos_dec[3:0];
   assign key_byte   = (pos_ff == '0) ? iv_ff : secret_all[secret_idx*BYTE_W +: BYTE_W];

   assign ks_sum   = j_ff + rd_data + key_byte;
   assign gen_sum  = j_ff + rd_data;
   assign out_addr = si_ff + sj_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = n_ff;
      wr_data = n_ff;
      rd_addr = i_ff + ADDR_W'(1);
      n_in    = n_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      pos_in  = pos_ff;
      si_in   = si_ff;
      sj_in   = sj_ff;
      iv_in   = iv_ff;
      text_in = text_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.start) begin
         iv_in  = req_data_byte;
         n_in   = '0;
         j_in   = '0;
         pos_in = '0;
      end
      if (cmd.cipher) begin
         text_in = req_data_byte;
         i_in    = i_ff + ADDR_W'(1);
      end
      if (cmd.init) begin
         wr_en   = 1'b1;
         rd_addr = '0;
         n_in    = n_ff + ADDR_W'(1);
      end
      if (cmd.ks_read) begin
         si_in   = rd_data;
         j_in    = ks_sum;
         rd_addr = ks_sum;
         pos_in  = (pos_ff == used_len) ? '0 : pos_ff + LEN_W'(1);
      end
      if (cmd.ks_wr_n) begin
         wr_en   = 1'b1;
         wr_data = rd_data;
      end
      if (cmd.ks_wr_j) begin
         wr_en   = 1'b1;
         wr_addr = j_ff;
         wr_data = si_ff;
         rd_addr = n_ff + ADDR_W'(1);
         n_in    = n_ff + ADDR_W'(1);
         if (n_ff == LAST_ENTRY) begin
            i_in = '0;
            j_in = '0;
         end
      end
      if (cmd.gen_read) begin
         si_in   = rd_data;
         j_in    = gen_sum;
         rd_addr = gen_sum;
      end
      if (cmd.gen_wr_i) begin
         sj_in   = rd_data;
         wr_en   = 1'b1;
         wr_addr = i_ff;
         wr_data = rd_data;
      end
      if (cmd.gen_wr_j) begin
         wr_en   = 1'b1;
         wr_addr = j_ff;
         wr_data = si_ff;
         rd_addr = out_addr;
      end
      if (cmd.gen_out) begin
         // hold the read address so the keystream byte stays put while stalled
         rd_addr = out_addr;
         if (out_free) begin
            rsp_byte_in  = text_ff ^ rd_data;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         len_ff       <= LEN_W'(3);
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_index == CSR_KEY_LOW)) begin
            key_low_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == CSR_KEY_HIGH)) begin
            key_high_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == CSR_LENGTH)) begin
            len_ff <= csr_wdata[LEN_W-1:0];
         end
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      pos_ff      <= pos_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      iv_ff       <= iv_in;
      text_ff     <= text_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign status.n_last   = (n_ff == LAST_ENTRY);
   assign status.out_free = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;

`ifndef NO_ASSERTIONS
   a_indices_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.ks_wr_j && status.n_last) |=> (i_ff == '0) && (j_ff == '0))
      else $error("indices not cleared after key schedule");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (cmd.gen_out && out_free) |=> rsp_valid_ff)
      else $error("result not presented after generator step");
`endif

endmodule

// ----- rtl/rc4iv_ctrl.sv -----
`timescale 1ns / 1ps

module rc4iv_ctrl
   import rc4iv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INIT  = 4'd1;
   localparam logic [3:0] ST_KS_RD = 4'd2;
   localparam logic [3:0] ST_KS_WN = 4'd3;
   localparam logic [3:0] ST_KS_WJ = 4'd4;
   localparam logic [3:0] ST_GN_RD = 4'd5;
   localparam logic [3:0] ST_GN_WI = 4'd6;
   localparam logic [3:0] ST_GN_WJ = 4'd7;
   localparam logic [3:0] ST_GN_OUT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.start    = accept && !req_action;
      cmd.cipher   = accept && req_action;
      cmd.init     = (state_ff == ST_INIT);
      cmd.ks_read  = (state_ff == ST_KS_RD);
      cmd.ks_wr_n  = (state_ff == ST_KS_WN);
      cmd.ks_wr_j  = (state_ff == ST_KS_WJ);
      cmd.gen_read = (state_ff == ST_GN_RD);
      cmd.gen_wr_i = (state_ff == ST_GN_WI);
      cmd.gen_wr_j = (state_ff == ST_GN_WJ);
      cmd.gen_out  = (state_ff == ST_GN_OUT);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_action ? ST_GN_RD : ST_INIT;
            end
         end
         ST_INIT: begin
            if (status.n_last) begin
               state_in = ST_KS_RD;
            end
         end
         ST_KS_RD: state_in = ST_KS_WN;
         ST_KS_WN: state_in = ST_KS_WJ;
         ST_KS_WJ: begin
            state_in = status.n_last ? ST_IDLE : ST_KS_RD;
         end
         ST_GN_RD: state_in = ST_GN_WI;
         ST_GN_WI: state_in = ST_GN_WJ;
         ST_GN_WJ: state_in = ST_GN_OUT;
         ST_GN_OUT: begin
            // hold until the result register is free
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GN_OUT && !status.out_free) |=> (state_ff == ST_GN_OUT))
      else $error("generator left output phase while result register busy");

   a_init_to_ks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT && status.n_last) |=> (state_ff == ST_KS_RD))
      else $error("key schedule did not follow identity fill");

   a_start_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_INIT))
      else $error("start transfer did not begin identity fill");
`endif

endmodule

// ----- rtl/rc4_iv_keyed_stream_cipher.sv -----
// Cipher byte: generator read, S[i] write, S[j] write, then the output phase, which holds
// until the result register is free. Start item: identity fill, then key schedule. Both are
// paced by the single read and write port of the permutation RAM; no item is taken until idle.
// Reset (synchronous) clears control and indices and returns the key registers to their
// defaults; the permutation is not cleared and holds nothing defined until the first start item.
`timescale 1ns / 1ps

module rc4_iv_keyed_stream_cipher
   import rc4iv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [BYTE_W-1:0]    req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_result_byte,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rc4iv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_action(req_action),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rc4iv_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_byte(rsp_result_byte),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
